>>> rtl/lvst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvst_pkg: shared types and constants of the light vote sun tracker
// Payload structs of both channels, the front-to-back job, the register file
// layout, register indexes, reset values and the fixed-point servo constants.
// ----------------------------------------------------------------------------
package lvst_pkg;

  localparam int HISTORY_DEPTH_DEF = 5;
  localparam int JOB_Q_DEPTH       = 2;
  localparam int RES_Q_DEPTH       = 2;

  localparam int MV_W     = 12;
  localparam int HOUR_W   = 5;
  localparam int ANGLE_W  = 8;
  localparam int CMPV_W   = 11;
  localparam int THR_W    = 5;
  localparam int CFG_A_W  = 3;
  localparam int CFG_D_W  = 12;

  // Register indexes on the configuration port.
  localparam logic [CFG_A_W-1:0] CFG_MARGIN_MV  = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_VOTE_THR   = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_STEP_DEG   = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_GAIN_X100  = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_NIGHT_HOUR = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_DAY_HOUR   = 3'd5;

  localparam logic [MV_W-1:0]    RST_MARGIN_MV  = 12'd20;
  localparam logic [THR_W-1:0]   RST_VOTE_THR   = 5'd3;
  localparam logic [ANGLE_W-1:0] RST_STEP_DEG   = 8'd10;
  localparam logic [7:0]         RST_GAIN_X100  = 8'd121;
  localparam logic [HOUR_W-1:0]  RST_NIGHT_HOUR = 5'd18;
  localparam logic [HOUR_W-1:0]  RST_DAY_HOUR   = 5'd6;

  // Decision codes.
  localparam logic [1:0] DEC_NONE  = 2'd0;
  localparam logic [1:0] DEC_LEFT  = 2'd1;
  localparam logic [1:0] DEC_RIGHT = 2'd2;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;

  // The compare value is 375 + floor(angle * gain / 48), since 18000 / 375 is 48.
  // The division is a shift by four followed by a multiply with ceil(2^13 / 3).
  localparam logic [CMPV_W-1:0] SERVO_BASE  = 11'd375;
  localparam logic [11:0]       RECIP_3     = 12'd2731;
  localparam int                RECIP_SHIFT = 13;

  typedef struct packed {
    logic [MV_W-1:0]   right_light_mv;
    logic [MV_W-1:0]   left_light_mv;
    logic [HOUR_W-1:0] hour_now;
  } lvst_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] pan_angle;
    logic [CMPV_W-1:0]  servo_compare;
    logic               command_valid;
    logic               night_mode;
    logic [1:0]         decision;
  } lvst_out_t;

  typedef struct packed {
    logic            night;
    logic [MV_W-1:0] right_mv;
    logic [MV_W-1:0] left_mv;
  } lvst_job_t;

  typedef struct packed {
    logic [MV_W-1:0]    margin_mv;
    logic [THR_W-1:0]   vote_threshold;
    logic [ANGLE_W-1:0] step_degrees;
    logic [7:0]         gain_x100;
    logic [HOUR_W-1:0]  night_start_hour;
    logic [HOUR_W-1:0]  day_start_hour;
  } lvst_cfg_t;

endpackage

>>> rtl/lvst_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvst_fifo: small register queue
// A few entries of any packed type, with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module lvst_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/lvst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvst_front: input stage of the sun tracker
// Classifies each reading as night or day and queues it for the back end.
// ----------------------------------------------------------------------------
module lvst_front
  import lvst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  lvst_in_t          in_data,
  output logic              in_full,
  input  logic [HOUR_W-1:0] night_start_hour,
  input  logic [HOUR_W-1:0] day_start_hour,
  input  logic              job_pop,
  output lvst_job_t         job,
  output logic              job_empty
);

  lvst_job_t job_in;

  always_comb begin
    job_in.night    = (in_data.hour_now >= night_start_hour) ||
                      (in_data.hour_now < day_start_hour);
    job_in.right_mv = in_data.right_light_mv;
    job_in.left_mv  = in_data.left_light_mv;
  end

  lvst_fifo #(
    .T     (lvst_job_t),
    .DEPTH (JOB_Q_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (job_in),
    .full  (in_full),
    .pop   (job_pop),
    .rdata (job),
    .empty (job_empty)
  );

endmodule

>>> rtl/lvst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvst_back: history, vote counter and pan angle update
// Keeps the reading history as a rotating register line, counts votes one
// pair per cycle, steps and clamps the angle and computes the servo value.
// ----------------------------------------------------------------------------
module lvst_back
  import lvst_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  lvst_cfg_t cfg,
  input  logic      job_empty,
  input  lvst_job_t job,
  output logic      job_pop,
  input  logic      res_full,
  output logic      res_push,
  output lvst_out_t res
);

  localparam int D      = HISTORY_DEPTH;
  localparam int IDX_W  = (D > 1) ? $clog2(D) : 1;
  localparam int FILL_W = $clog2(D + 1);
  localparam int CNT_W  = $clog2(D * D + 1);
  localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CMP    = 7'b0000010,
    S_SKEW   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_MUL    = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  logic [MV_W-1:0]    left_hist_r  [D];
  logic [MV_W-1:0]    right_hist_r [D];
  logic [FILL_W-1:0]  fill_r;
  logic [FILL_W-1:0]  fill_nxt;
  logic [ANGLE_W-1:0] angle_r;
  logic [ANGLE_W-1:0] angle_nxt;
  logic [IDX_W-1:0]   j_r;
  logic [IDX_W-1:0]   j_nxt;
  logic [IDX_W-1:0]   p_r;
  logic [IDX_W-1:0]   p_nxt;
  logic [CNT_W-1:0]   lv_r;
  logic [CNT_W-1:0]   lv_nxt;
  logic [CNT_W-1:0]   rv_r;
  logic [CNT_W-1:0]   rv_nxt;
  logic [MV_W-1:0]    outer_l_r;
  logic [MV_W-1:0]    outer_rt_r;
  logic               night_r;
  logic               night_nxt;
  logic               cmd_r;
  logic               cmd_nxt;
  logic [1:0]         decision_r;
  logic [1:0]         decision_nxt;
  logic [15:0]        prod_r;
  logic [15:0]        prod_nxt;
  logic [CMPV_W-1:0]  cmpv_r;
  logic [CMPV_W-1:0]  cmpv_nxt;
  logic               hist_shift;
  logic               hist_rot;
  logic [MV_W-1:0]    outer_l;
  logic [MV_W-1:0]    outer_rt;
  logic [MV_W:0]      right_sum;
  logic [MV_W:0]      left_sum;
  logic               left_hit;
  logic               right_hit;
  logic [ANGLE_W:0]   angle_up;
  logic [23:0]        quot_full;

  // The outer element of a pass sits at the head of the line in its first cycle.
  assign outer_l   = (j_r == '0) ? left_hist_r[0] : outer_l_r;
  assign outer_rt  = (j_r == '0) ? right_hist_r[0] : outer_rt_r;
  assign right_sum = (MV_W+1)'(right_hist_r[0]) + (MV_W+1)'(cfg.margin_mv);
  assign left_sum  = (MV_W+1)'(left_hist_r[0]) + (MV_W+1)'(cfg.margin_mv);
  assign left_hit  = (MV_W+1)'(outer_l) > right_sum;
  assign right_hit = (MV_W+1)'(outer_rt) > left_sum;
  assign angle_up  = (ANGLE_W+1)'(angle_r) + (ANGLE_W+1)'(cfg.step_degrees);
  assign quot_full = 24'(prod_r[15:4]) * 24'(RECIP_3);

  assign job_pop  = (state_r == S_IDLE) && !job_empty;
  assign res_push = (state_r == S_OUT) && !res_full;

  always_comb begin
    res.pan_angle     = angle_r;
    res.servo_compare = cmpv_r;
    res.command_valid = cmd_r;
    res.night_mode    = night_r;
    res.decision      = decision_r;
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    angle_nxt    = angle_r;
    j_nxt        = j_r;
    p_nxt        = p_r;
    lv_nxt       = lv_r;
    rv_nxt       = rv_r;
    night_nxt    = night_r;
    cmd_nxt      = cmd_r;
    decision_nxt = decision_r;
    prod_nxt     = prod_r;
    cmpv_nxt     = cmpv_r;
    hist_shift   = 1'b0;
    hist_rot     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          night_nxt    = job.night;
          decision_nxt = DEC_NONE;
          cmd_nxt      = 1'b0;
          if (job.night) begin
            cmd_nxt   = (angle_r != '0);
            angle_nxt = '0;
            state_nxt = S_MUL;
          end else begin
            hist_shift = 1'b1;
            if (fill_r == FILL_W'(D - 1)) begin
              fill_nxt  = '0;
              j_nxt     = '0;
              p_nxt     = '0;
              lv_nxt    = '0;
              rv_nxt    = '0;
              state_nxt = S_CMP;
            end else begin
              fill_nxt  = fill_r + 1'b1;
              state_nxt = S_MUL;
            end
          end
        end
      end
      S_CMP: begin
        hist_rot = 1'b1;
        lv_nxt   = lv_r + CNT_W'(left_hit);
        rv_nxt   = rv_r + CNT_W'(right_hit);
        if (j_r == IDX_W'(D - 1)) begin
          j_nxt     = '0;
          state_nxt = S_SKEW;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_SKEW: begin
        hist_rot = 1'b1;
        if (p_r == IDX_W'(D - 1)) begin
          state_nxt = S_DECIDE;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_DECIDE: begin
        cmd_nxt   = (lv_r != '0) || (rv_r != '0);
        state_nxt = S_MUL;
        if (CMP_W'(lv_r) >= CMP_W'(cfg.vote_threshold)) begin
          decision_nxt = DEC_LEFT;
          angle_nxt    = (angle_up > (ANGLE_W+1)'(ANGLE_MAX)) ? ANGLE_MAX
                                                              : angle_up[ANGLE_W-1:0];
        end else if (CMP_W'(rv_r) >= CMP_W'(cfg.vote_threshold)) begin
          decision_nxt = DEC_RIGHT;
          angle_nxt    = (cfg.step_degrees > angle_r) ? '0 : angle_r - cfg.step_degrees;
        end
      end
      S_MUL: begin
        prod_nxt  = 16'(angle_r) * 16'(cfg.gain_x100);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmpv_nxt  = SERVO_BASE + quot_full[RECIP_SHIFT +: CMPV_W];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      angle_r <= '0;
      j_r     <= '0;
      p_r     <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      angle_r <= angle_nxt;
      j_r     <= j_nxt;
      p_r     <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lv_r       <= lv_nxt;
    rv_r       <= rv_nxt;
    night_r    <= night_nxt;
    cmd_r      <= cmd_nxt;
    decision_r <= decision_nxt;
    prod_r     <= prod_nxt;
    cmpv_r     <= cmpv_nxt;
    if (state_r == S_CMP && j_r == '0) begin
      outer_l_r  <= left_hist_r[0];
      outer_rt_r <= right_hist_r[0];
    end
  end

  // New readings enter at the head; during a vote the line rotates toward the head.
  for (genvar g = 0; g < D; g++) begin : g_hist
    localparam int NXT = (g == D - 1) ? 0 : g + 1;
    localparam int PRV = (g == 0) ? 0 : g - 1;

    always_ff @(posedge clk) begin
      if (hist_shift) begin
        left_hist_r[g]  <= (g == 0) ? job.left_mv : left_hist_r[PRV];
        right_hist_r[g] <= (g == 0) ? job.right_mv : right_hist_r[PRV];
      end else if (hist_rot) begin
        left_hist_r[g]  <= left_hist_r[NXT];
        right_hist_r[g] <= right_hist_r[NXT];
      end
    end
  end

endmodule

>>> rtl/light_vote_sun_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_vote_sun_tracker: pan-axis sun tracker deciding by vote count against a threshold
// Readings enter on a queue-style push/full port and results leave on a
// pop/empty port; one result is produced for every reading.
//
// Usage: push a reading while in_full is low. The oldest result is shown on
// out_data while out_empty is low and leaves when out_pop is high. Registers
// are written through cfg_valid/cfg_ready (always ready) with cfg_addr as
// the register index, while no reading is in flight.
// Back end: night readings and day readings that do not complete the
// history pass the multiply, divide and output states; a reading that
// completes the history first passes the vote counter, which compares
// one pair per cycle in its compare state with a skew step after each
// pass. Two queue entries sit on each side of the back end.
// Reset clears the queues, the fill count, the angle and the registers to
// their defaults. If the receiver stalls, finished results wait in the
// output queue and the input queue keeps accepting until both are full.
// ----------------------------------------------------------------------------
module light_vote_sun_tracker
  import lvst_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  lvst_in_t           in_data,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output lvst_out_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata
);

  lvst_cfg_t cfg_r;
  lvst_cfg_t cfg_nxt;
  lvst_job_t job;
  logic      job_empty;
  logic      job_pop;
  lvst_out_t res;
  logic      res_push;
  logic      res_full;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_MARGIN_MV:  cfg_nxt.margin_mv        = cfg_wdata;
        CFG_VOTE_THR:   cfg_nxt.vote_threshold   = cfg_wdata[THR_W-1:0];
        CFG_STEP_DEG:   cfg_nxt.step_degrees     = cfg_wdata[ANGLE_W-1:0];
        CFG_GAIN_X100:  cfg_nxt.gain_x100        = cfg_wdata[7:0];
        CFG_NIGHT_HOUR: cfg_nxt.night_start_hour = cfg_wdata[HOUR_W-1:0];
        CFG_DAY_HOUR:   cfg_nxt.day_start_hour   = cfg_wdata[HOUR_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.margin_mv        <= RST_MARGIN_MV;
      cfg_r.vote_threshold   <= RST_VOTE_THR;
      cfg_r.step_degrees     <= RST_STEP_DEG;
      cfg_r.gain_x100        <= RST_GAIN_X100;
      cfg_r.night_start_hour <= RST_NIGHT_HOUR;
      cfg_r.day_start_hour   <= RST_DAY_HOUR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lvst_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_data          (in_data),
    .in_full          (in_full),
    .night_start_hour (cfg_r.night_start_hour),
    .day_start_hour   (cfg_r.day_start_hour),
    .job_pop          (job_pop),
    .job              (job),
    .job_empty        (job_empty)
  );

  lvst_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_empty (job_empty),
    .job       (job),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  lvst_fifo #(
    .T     (lvst_out_t),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

>>> rtl/lvst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvst_checker: port-level checks of the sun tracker
// Watches the result channel for reset behavior, stall holding, value ranges and night results.
// ----------------------------------------------------------------------------
module lvst_checker
  import lvst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_empty,
  input logic      out_pop,
  input lvst_out_t out_data
);

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed or vanished");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.pan_angle <= ANGLE_MAX))
    else $error("pan angle out of range");

  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.servo_compare >= SERVO_BASE &&
                    out_data.servo_compare <= 11'd1331))
    else $error("servo compare value out of range");

  a_night_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.night_mode) |->
      (out_data.decision == DEC_NONE && out_data.pan_angle == '0))
    else $error("night result stepped or left the angle off zero");

endmodule

bind light_vote_sun_tracker lvst_checker u_lvst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
